// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level RTL file of the GEMM tile block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

`endif

// ===== src/igxd_pkg.sv =====
// ----------------------------------------------------------------------------
// igxd_pkg
// Types, constants and arithmetic helpers of the int8 GEMM tile block.
// ----------------------------------------------------------------------------
package igxd_pkg;

    localparam int ROWS  = 8;
    localparam int COLS  = 16;
    localparam int ACC_W = 32;
    localparam int COL_W = $clog2(COLS);
    localparam int CNT_W = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_EN  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_ACC       = 2'd0,
        CMD_COMP      = 2'd1,
        CMD_MILESTONE = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic             en;
        t_cmd             cmd;
        logic             fast;
        logic [COL_W-1:0] comp_col;
        logic [ACC_W-1:0] comp_val;
    } t_tile_ctl;

    // In exact mode a negative A byte is folded into B, so the multiplicand
    // is always an unsigned magnitude.
    function automatic logic signed [16:0] byte_prod(logic [7:0] a, logic [7:0] b,
                                                     logic fast);
        logic [7:0]         m;
        logic [7:0]         s;
        logic signed [8:0]  ms;
        logic signed [7:0]  ss;
        m = a;
        s = b;
        if (!fast && a[7]) begin
            m = 8'(-a);
            s = 8'(-b);
        end
        ms = $signed({1'b0, m});
        ss = $signed(s);
        return ms * ss;
    endfunction

    function automatic logic [15:0] sat16(logic signed [17:0] v);
        logic [15:0] res;
        if (v > 18'sd32767) begin
            res = 16'h7FFF;
        end else if (v < -18'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ===== src/igxd_tile.sv =====
// ----------------------------------------------------------------------------
// igxd_tile
// The 8x16 array of 32-bit accumulator cells with their multiply, saturate,
// add, compensate and clear logic, plus the per-column XOR of the cell contents.
// ----------------------------------------------------------------------------
module igxd_tile (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  igxd_pkg::t_tile_ctl                    i_ctl,
    input  logic [63:0]                            i_a_lo,
    input  logic [63:0]                            i_a_hi,
    input  logic [63:0]                            i_b0,
    input  logic [63:0]                            i_b1,
    input  logic [63:0]                            i_b2,
    input  logic [63:0]                            i_b3,
    output logic [igxd_pkg::COLS-1:0][igxd_pkg::ACC_W-1:0] o_col_xor
);
    import igxd_pkg::*;

    logic [ACC_W-1:0] r_acc [ROWS][COLS];
    logic [ACC_W-1:0] n_acc [ROWS][COLS];
    logic [63:0]      b_word [4];

    assign b_word[0] = i_b0;
    assign b_word[1] = i_b1;
    assign b_word[2] = i_b2;
    assign b_word[3] = i_b3;

    always_comb begin : cell_next
        logic [63:0]        aw;
        logic [63:0]        bw;
        logic signed [17:0] sum;
        logic [15:0]        sat;
        for (int r = 0; r < ROWS; r++) begin
            aw = (r < 4) ? i_a_lo : i_a_hi;
            for (int c = 0; c < COLS; c++) begin
                bw  = b_word[c / 4];
                sum = 18'(byte_prod(aw[16*(r%4) +: 8], bw[16*(c%4) +: 8], i_ctl.fast))
                    + 18'(byte_prod(aw[16*(r%4)+8 +: 8], bw[16*(c%4)+8 +: 8], i_ctl.fast));
                sat = sat16(sum);
                case (i_ctl.cmd)
                    CMD_ACC: begin
                        n_acc[r][c] = r_acc[r][c] + {{(ACC_W-16){sat[15]}}, sat};
                    end
                    CMD_COMP: begin
                        n_acc[r][c] = (i_ctl.fast && i_ctl.comp_col == COL_W'(c))
                                    ? r_acc[r][c] + i_ctl.comp_val : r_acc[r][c];
                    end
                    CMD_CLEAR: begin
                        n_acc[r][c] = '0;
                    end
                    default: begin
                        n_acc[r][c] = r_acc[r][c];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    r_acc[r][c] <= '0;
                end
            end
        end else if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            o_col_xor[c] = '0;
            for (int r = 0; r < ROWS; r++) begin
                o_col_xor[c] = o_col_xor[c] ^ r_acc[r][c];
            end
        end
    end

endmodule

// ===== src/igxd_fold.sv =====
// ----------------------------------------------------------------------------
// igxd_fold
// Captures the column XORs of a milestone, folds them into the digest and
// holds the result item in the output register until it is taken.
// ----------------------------------------------------------------------------
module igxd_fold (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic [igxd_pkg::COLS-1:0][igxd_pkg::ACC_W-1:0] i_col_xor,
    input  logic [igxd_pkg::CNT_W-1:0]             i_idx,
    output logic                                   o_pv_free,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [igxd_pkg::ACC_W-1:0]             o_digest,
    output logic [igxd_pkg::CNT_W-1:0]             o_index
);
    import igxd_pkg::*;

    logic                         r_pv;
    logic [COLS-1:0][ACC_W-1:0]   r_part;
    logic [CNT_W-1:0]             r_pidx;
    logic                         r_out_valid;
    logic [ACC_W-1:0]             r_digest;
    logic [CNT_W-1:0]             r_index;
    logic                         out_free;
    logic [ACC_W-1:0]             n_digest;

    assign out_free  = !r_out_valid || i_ready;
    assign o_pv_free = !r_pv || out_free;

    always_comb begin
        n_digest = '0;
        for (int c = 0; c < COLS; c++) begin
            n_digest = n_digest ^ r_part[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_pv <= 1'b1;
            end else if (out_free) begin
                r_pv <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_part <= i_col_xor;
            r_pidx <= i_idx;
        end
        if (out_free && r_pv) begin
            r_digest <= n_digest;
            r_index  <= r_pidx;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_digest = r_digest;
    assign o_index  = r_index;

endmodule

// ===== src/int8_gemm_tile_xor_digest.sv =====
// ----------------------------------------------------------------------------
// int8_gemm_tile_xor_digest
// An 8x16 tile of 32-bit int8 GEMM accumulators with column compensation,
// clearing, and an XOR digest of the tile at each milestone end while digest_enable is set.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle unless a milestone digest waits for the fold
// stage; the single-pass update of all 128 cells is the limit. An accepted item
// is registered and updates the cells in the following cycle. A milestone digest
// is registered as the 16 column XORs, then folded into the output register.
// Synchronous active-low reset zeroes all cells and the milestone count, and
// sets fast_mode to 0 and digest_enable to 1; no clearing pass follows.
module int8_gemm_tile_xor_digest (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_command,
    input  logic [63:0]                         i_a_rows_low,
    input  logic [63:0]                         i_a_rows_high,
    input  logic [63:0]                         i_b_cols_0,
    input  logic [63:0]                         i_b_cols_1,
    input  logic [63:0]                         i_b_cols_2,
    input  logic [63:0]                         i_b_cols_3,
    input  logic [igxd_pkg::COL_W-1:0]          i_comp_column,
    input  logic signed [31:0]                  i_comp_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [31:0]                         o_digest,
    output logic [igxd_pkg::CNT_W-1:0]          o_milestone_index,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [igxd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [igxd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import igxd_pkg::*;

    `include "assert_macros.svh"

    logic                       r_fast;
    logic                       r_digest_en;
    logic [CNT_W-1:0]           r_ms_count;

    logic                       r_ex_valid;
    t_cmd                       r_ex_cmd;
    logic [63:0]                r_a_lo;
    logic [63:0]                r_a_hi;
    logic [63:0]                r_b0;
    logic [63:0]                r_b1;
    logic [63:0]                r_b2;
    logic [63:0]                r_b3;
    logic [COL_W-1:0]           r_comp_col;
    logic [ACC_W-1:0]           r_comp_val;

    logic                       ms_emit;
    logic                       ms_fire;
    logic                       ex_ok;
    logic                       ex_fire;
    logic                       pv_free;
    logic                       in_fire;
    t_tile_ctl                  tile_ctl;
    logic [COLS-1:0][ACC_W-1:0] col_xor;

    assign o_cfg_ready = 1'b1;

    assign ms_emit    = (r_ex_cmd == CMD_MILESTONE) && r_digest_en;
    assign ex_ok      = !ms_emit || pv_free;
    assign ex_fire    = r_ex_valid && ex_ok;
    assign ms_fire    = ex_fire && (r_ex_cmd == CMD_MILESTONE);
    assign o_in_ready = !r_ex_valid || ex_ok;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast      <= 1'b0;
            r_digest_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAST_MODE: begin
                    r_fast <= i_cfg_data[0];
                end
                CFG_DIGEST_EN: begin
                    r_digest_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_ex_cmd   <= CMD_ACC;
            r_ms_count <= '0;
        end else begin
            if (in_fire) begin
                r_ex_valid <= 1'b1;
                r_ex_cmd   <= t_cmd'(i_command);
            end else if (ex_fire) begin
                r_ex_valid <= 1'b0;
            end
            if (ms_fire) begin
                r_ms_count <= r_ms_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_lo     <= i_a_rows_low;
            r_a_hi     <= i_a_rows_high;
            r_b0       <= i_b_cols_0;
            r_b1       <= i_b_cols_1;
            r_b2       <= i_b_cols_2;
            r_b3       <= i_b_cols_3;
            r_comp_col <= i_comp_column;
            r_comp_val <= i_comp_value;
        end
    end

    always_comb begin
        tile_ctl.en       = ex_fire;
        tile_ctl.cmd      = r_ex_cmd;
        tile_ctl.fast     = r_fast;
        tile_ctl.comp_col = r_comp_col;
        tile_ctl.comp_val = r_comp_val;
    end

    igxd_tile u_tile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tile_ctl),
        .i_a_lo    (r_a_lo),
        .i_a_hi    (r_a_hi),
        .i_b0      (r_b0),
        .i_b1      (r_b1),
        .i_b2      (r_b2),
        .i_b3      (r_b3),
        .o_col_xor (col_xor)
    );

    igxd_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (ex_fire && ms_emit),
        .i_col_xor (col_xor),
        .i_idx     (r_ms_count),
        .o_pv_free (pv_free),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_digest  (o_digest),
        .o_index   (o_milestone_index)
    );

    `ASSERT_NEXT(a_count_step, i_clk, i_rst_n, ms_fire, r_ms_count == $past(r_ms_count) + CNT_W'(1))
    `ASSERT_NEXT(a_count_holds, i_clk, i_rst_n, !ms_fire, $stable(r_ms_count))
    `ASSERT_NEXT(a_exec_holds, i_clk, i_rst_n, r_ex_valid && !ex_ok, r_ex_valid && $stable(r_ex_cmd))
    `ASSERT_SAME(a_only_digest_stalls, i_clk, i_rst_n, r_ex_valid && !ex_ok, ms_emit && !o_in_ready)

endmodule
